>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked on the rising edge, off while reset is held.
`define UTT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Same, with a message of its own.
`define UTT_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

>>> rtl/utt_pkg.sv
// Types, constants and helper functions of the UTF text to UTF-16 word splitter.
package utt_pkg;

    localparam logic [1:0] ENC_UTF8    = 2'd0;
    localparam logic [1:0] ENC_UTF16LE = 2'd1;
    localparam logic [1:0] ENC_UTF16BE = 2'd2;

    localparam logic [31:0] BMP_MAX   = 32'h0000_FFFF;
    localparam logic [31:0] UNI_MAX   = 32'h0010_FFFF;
    localparam logic [31:0] SUPP_BASE = 32'h0001_0000;

    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;
    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [15:0] BOM         = 16'hFEFF;
    localparam logic [15:0] LF          = 16'h000A;
    localparam logic [15:0] CR          = 16'h000D;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        word_end;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_res_pair;

    function automatic logic [2:0] cont_count(input logic [7:0] b);
        logic [2:0] len;
        case (b) inside
            [8'h00:8'hBF]: len = 3'd0;
            [8'hC0:8'hDF]: len = 3'd1;
            [8'hE0:8'hEF]: len = 3'd2;
            [8'hF0:8'hF7]: len = 3'd3;
            [8'hF8:8'hFB]: len = 3'd4;
            default:       len = 3'd5;
        endcase
        return len;
    endfunction

    function automatic logic [31:0] lead_offset(input logic [2:0] seq);
        logic [31:0] ofs;
        case (seq)
            3'd0:    ofs = 32'h0000_0000;
            3'd1:    ofs = 32'h0000_3080;
            3'd2:    ofs = 32'h000E_2080;
            3'd3:    ofs = 32'h03C8_2080;
            3'd4:    ofs = 32'hFA08_2080;
            default: ofs = 32'h8208_2080;
        endcase
        return ofs;
    endfunction

endpackage

>>> rtl/utt_decoder.sv
// Decoder state and the single-pass logic that turns one byte into up to two results.
module utt_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [7:0]          i_data_byte,
    input  logic                i_stream_end,
    input  logic [1:0]          i_encoding,
    output utt_pkg::t_res_pair  o_res
);

    logic [31:0] r_acc,  n_acc;
    logic [2:0]  r_need, n_need;
    logic [2:0]  r_seq,  n_seq;
    logic        r_word_open, n_word_open;
    logic [7:0]  r_held, n_held;
    logic        r_phase, n_phase;

    logic [31:0] acc_shift;
    logic [31:0] v;
    logic [31:0] w;
    logic [2:0]  len;
    logic        done;
    logic        unit_go;
    logic [15:0] unit16;

    always_comb begin
        n_acc       = r_acc;
        n_need      = r_need;
        n_seq       = r_seq;
        n_word_open = r_word_open;
        n_held      = r_held;
        n_phase     = r_phase;
        o_res       = '0;
        unit_go     = 1'b0;
        unit16      = '0;
        done        = 1'b0;
        len         = utt_pkg::cont_count(i_data_byte);
        acc_shift   = {r_acc[25:0], 6'b0} + {24'b0, i_data_byte};
        v           = '0;
        w           = '0;

        if (i_stream_end) begin
            if (r_word_open) begin
                o_res.count = 2'd1;
                o_res.r0    = '{code_unit: 16'h0000, word_end: 1'b1, last_of_run: 1'b1};
            end
            n_acc       = '0;
            n_need      = '0;
            n_seq       = '0;
            n_word_open = 1'b0;
            n_held      = '0;
            n_phase     = 1'b0;
        end else if (i_encoding == utt_pkg::ENC_UTF16LE ||
                     i_encoding == utt_pkg::ENC_UTF16BE) begin
            if (!r_phase) begin
                n_held  = i_data_byte;
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
                unit_go = 1'b1;
                unit16  = (i_encoding == utt_pkg::ENC_UTF16BE) ? {r_held, i_data_byte}
                                                                : {i_data_byte, r_held};
            end
        end else begin
            if (r_need == 3'd0) begin
                n_acc  = {24'b0, i_data_byte};
                n_need = len;
                n_seq  = len;
                done   = (len == 3'd0);
            end else begin
                n_acc  = acc_shift;
                n_need = r_need - 3'd1;
                done   = (r_need == 3'd1);
            end
            v = n_acc - utt_pkg::lead_offset(n_seq);
            w = v - utt_pkg::SUPP_BASE;
            if (done) begin
                if (v <= utt_pkg::BMP_MAX) begin
                    if (v[15:0] != utt_pkg::BOM) begin
                        unit_go = 1'b1;
                        unit16  = v[15:0];
                    end
                end else if (v <= utt_pkg::UNI_MAX) begin
                    n_word_open = 1'b1;
                    o_res.count = 2'd2;
                    o_res.r0    = '{code_unit: utt_pkg::HI_SURR + {6'b0, w[19:10]},
                                    word_end: 1'b0, last_of_run: 1'b0};
                    o_res.r1    = '{code_unit: utt_pkg::LO_SURR + {6'b0, w[9:0]},
                                    word_end: 1'b0, last_of_run: 1'b1};
                end else begin
                    n_word_open = 1'b1;
                    o_res.count = 2'd1;
                    o_res.r0    = '{code_unit: utt_pkg::REPLACEMENT,
                                    word_end: 1'b0, last_of_run: 1'b1};
                end
            end
        end

        if (unit_go) begin
            if (unit16 == utt_pkg::LF || unit16 == utt_pkg::CR) begin
                if (r_word_open) begin
                    n_word_open = 1'b0;
                    o_res.count = 2'd1;
                    o_res.r0    = '{code_unit: 16'h0000, word_end: 1'b1, last_of_run: 1'b1};
                end
            end else begin
                n_word_open = 1'b1;
                o_res.count = 2'd1;
                o_res.r0    = '{code_unit: unit16, word_end: 1'b0, last_of_run: 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_need      <= '0;
            r_seq       <= '0;
            r_word_open <= 1'b0;
            r_held      <= '0;
            r_phase     <= 1'b0;
        end else if (i_advance) begin
            r_acc       <= n_acc;
            r_need      <= n_need;
            r_seq       <= n_seq;
            r_word_open <= n_word_open;
            r_held      <= n_held;
            r_phase     <= n_phase;
        end
    end

endmodule

>>> rtl/utt_result_fifo.sv
// Four-entry result queue: takes up to two results per cycle while it has room, delivers one while the reader is ready.
module utt_result_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  utt_pkg::t_res_pair  i_res,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output utt_pkg::t_result    o_result
);

    utt_pkg::t_result r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_count, n_count;
    logic       pop;
    logic [2:0] push_n;

    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_count != 3'd0);
    assign o_result = r_mem[r_rd];
    assign o_room   = (r_count <= 3'd2) || (r_count == 3'd3 && pop);
    assign push_n   = i_push ? {1'b0, i_res.count} : 3'd0;

    always_comb begin
        n_wr    = r_wr + push_n[1:0];
        n_rd    = r_rd + {1'b0, pop};
        n_count = r_count + push_n - {2'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 3'd0) begin
            r_mem[r_wr] <= i_res.r0;
        end
        if (push_n == 3'd2) begin
            r_mem[r_wr + 2'd1] <= i_res.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/utf_text_to_utf16_word_splitter.sv
// Top level of the UTF text to UTF-16 word splitter.
// Accepts one file byte per cycle into an input register while o_ready is high; the
// decoder then turns it into zero, one or two results (a surrogate pair) and pushes them
// into a four-entry result queue once it has room, from which the output side takes one
// result per cycle while i_ready is high. Bytes sustain one per cycle while each yields
// at most one result and the output is ready; the queue's single read port hands out a
// surrogate pair one result at a time. The encoding register is always ready; the user
// must write it only while the block is idle, as the block itself does not enforce this.
module utf_text_to_utf16_word_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code_unit,
    output logic        o_word_end,
    output logic        o_last_of_run
);

    logic [1:0] r_encoding;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       room;
    logic       advance;

    utt_pkg::t_res_pair res;
    utt_pkg::t_result   head;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && room;
    assign o_ready     = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoding <= utt_pkg::ENC_UTF8;
        end else if (i_cfg_valid) begin
            r_encoding <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_stream_end;
        end
    end

    utt_decoder u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_data_byte  (r_in_byte),
        .i_stream_end (r_in_end),
        .i_encoding   (r_encoding),
        .o_res        (res)
    );

    utt_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (advance),
        .i_res    (res),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (head)
    );

    assign o_code_unit   = head.code_unit;
    assign o_word_end    = head.word_end;
    assign o_last_of_run = head.last_of_run;

endmodule

>>> rtl/utt_checker.sv
// Port-level assertions for the word splitter, bound to the top level.
`include "assert_macros.svh"

module utt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_code_unit,
    input logic        o_word_end,
    input logic        o_last_of_run
);

    `UTT_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_valid && !i_ready |=> o_valid && $stable({o_code_unit, o_word_end, o_last_of_run}))
    `UTT_ASSERT_MSG(a_end_zero, i_clk, i_rst_n,
        o_valid && o_word_end |-> o_code_unit == 16'h0000, "word end carries a unit")
    `UTT_ASSERT_MSG(a_end_last, i_clk, i_rst_n,
        o_valid && o_word_end |-> o_last_of_run, "word end not last of run")
    `UTT_ASSERT(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid |-> o_cfg_ready)
    `UTT_ASSERT_MSG(a_in_free, i_clk, i_rst_n, !o_valid |-> o_ready, "input stalled while empty")

endmodule

bind utf_text_to_utf16_word_splitter utt_checker u_checker (.*);

>>> tb/sv/utt_stream_checker.sv
// Checker for the UTF text to UTF-16 word splitter: predicts results and compares them.
module utt_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_unit,
    input  logic        i_out_word_end,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_words
);

    logic [31:0] acc;
    logic [2:0]  need;
    logic [2:0]  seq_len;
    logic        word_open;
    logic [7:0]  held;
    logic        pair_phase;
    logic [1:0]  enc;

    utt_pkg::t_result expected_units[$];
    utt_pkg::t_result fresh[2];
    int               n_fresh;
    int               fail_count = 0;
    int               checked = 0;
    int               words = 0;

    function automatic logic [2:0] trailing_count(input logic [7:0] b);
        if (b[7:6] != 2'b11) return 3'd0;
        if (!b[5]) return 3'd1;
        if (!b[4]) return 3'd2;
        if (!b[3]) return 3'd3;
        if (!b[2]) return 3'd4;
        return 3'd5;
    endfunction

    function automatic logic [31:0] seq_offset(input logic [2:0] n);
        case (n)
            3'd0:    return 32'h0000_0000;
            3'd1:    return 32'h0000_3080;
            3'd2:    return 32'h000E_2080;
            3'd3:    return 32'h03C8_2080;
            3'd4:    return 32'hFA08_2080;
            default: return 32'h8208_2080;
        endcase
    endfunction

    task automatic emit(input logic [15:0] unit, input logic close);
        fresh[n_fresh].code_unit   = unit;
        fresh[n_fresh].word_end    = close;
        fresh[n_fresh].last_of_run = 1'b0;
        n_fresh++;
    endtask

    task automatic append_unit(input logic [15:0] unit);
        if (unit == utt_pkg::LF || unit == utt_pkg::CR) begin
            if (word_open) begin
                word_open = 1'b0;
                emit(16'h0000, 1'b1);
            end
        end else begin
            word_open = 1'b1;
            emit(unit, 1'b0);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic stream_end);
        logic [31:0] v;
        n_fresh = 0;
        if (stream_end) begin
            if (word_open) emit(16'h0000, 1'b1);
            acc        = '0;
            need       = '0;
            seq_len    = '0;
            word_open  = 1'b0;
            held       = '0;
            pair_phase = 1'b0;
        end else if (enc == utt_pkg::ENC_UTF16LE || enc == utt_pkg::ENC_UTF16BE) begin
            if (!pair_phase) begin
                held       = b;
                pair_phase = 1'b1;
            end else begin
                pair_phase = 1'b0;
                append_unit(enc == utt_pkg::ENC_UTF16BE ? {held, b} : {b, held});
            end
        end else begin
            if (need == 3'd0) begin
                seq_len = trailing_count(b);
                need    = seq_len;
                acc     = {24'h0, b};
            end else begin
                acc  = (acc << 6) + {24'h0, b};
                need = need - 3'd1;
            end
            if (need == 3'd0) begin
                v = acc - seq_offset(seq_len);
                if (v <= utt_pkg::BMP_MAX) begin
                    if (v[15:0] != utt_pkg::BOM) append_unit(v[15:0]);
                end else if (v <= utt_pkg::UNI_MAX) begin
                    v         = v - utt_pkg::SUPP_BASE;
                    word_open = 1'b1;
                    emit(utt_pkg::HI_SURR + {6'h0, v[19:10]}, 1'b0);
                    emit(utt_pkg::LO_SURR + {6'h0, v[9:0]}, 1'b0);
                end else begin
                    word_open = 1'b1;
                    emit(utt_pkg::REPLACEMENT, 1'b0);
                end
            end
        end
        if (n_fresh > 0) fresh[n_fresh - 1].last_of_run = 1'b1;
        for (int k = 0; k < n_fresh; k++) expected_units = {expected_units, fresh[k]};
    endtask

    always @(posedge i_clk) begin
        utt_pkg::t_result want;
        if (!i_rst_n) begin
            acc        = '0;
            need       = '0;
            seq_len    = '0;
            word_open  = 1'b0;
            held       = '0;
            pair_phase = 1'b0;
            enc        = utt_pkg::ENC_UTF8;
            expected_units.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) enc = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (expected_units.size() == 0) begin
                    $error("unexpected result: code_unit %h word_end %b last_of_run %b",
                           i_out_unit, i_out_word_end, i_out_last);
                    fail_count++;
                end else begin
                    want = expected_units.pop_front();
                    checked++;
                    if (want.word_end) words++;
                    if (i_out_unit !== want.code_unit) begin
                        $error("code_unit: expected %h, got %h", want.code_unit, i_out_unit);
                        fail_count++;
                    end
                    if (i_out_word_end !== want.word_end) begin
                        $error("word_end: expected %b, got %b", want.word_end, i_out_word_end);
                        fail_count++;
                    end
                    if (i_out_last !== want.last_of_run) begin
                        $error("last_of_run: expected %b, got %b",
                               want.last_of_run, i_out_last);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) decode_byte(i_in_byte, i_in_end);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_units.size();
        o_checked    <= checked;
        o_words      <= words;
    end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the UTF text to UTF-16 word splitter: stimulus, flow control, verdict.
module tb_top;

    localparam logic [1:0] ENC_SPARE = 2'd3;
    localparam int         HOLD_CYCLES = 64;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data = 2'd0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stream_end = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_code_unit;
    logic        o_word_end;
    logic        o_last_of_run;

    int fail_count;
    int pending;
    int checked;
    int words;

    int         sent = 0;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    logic [1:0] cur_enc = utt_pkg::ENC_UTF8;
    logic       hold_req = 1'b0;
    logic       hold_ack = 1'b0;
    int         hold_left = 0;

    utf_text_to_utf16_word_splitter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_stream_end  (i_stream_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_unit   (o_code_unit),
        .o_word_end    (o_word_end),
        .o_last_of_run (o_last_of_run)
    );

    utt_stream_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_in_byte      (i_data_byte),
        .i_in_end       (i_stream_end),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_out_unit     (o_code_unit),
        .i_out_word_end (o_word_end),
        .i_out_last     (o_last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_words        (words)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            i_ready   <= 1'b0;
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        #(8 * 500_000);
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_item(input logic [7:0] b, input logic e);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_stream_end <= e;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    function automatic logic [7:0] cont_byte();
        logic [5:0] low;
        low = 6'($urandom_range(63));
        if ($urandom_range(7) == 0) return 8'($urandom_range(255));
        return {2'b10, low};
    endfunction

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_encoding(input logic [1:0] enc);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= enc;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_enc = enc;
    endtask

    task automatic utf8_char();
        int          pick;
        int          n;
        logic [20:0] cp;
        logic [7:0]  lead;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_item(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
        end else if (pick < 38) begin
            send_item($urandom_range(1) ? utt_pkg::CR[7:0] : utt_pkg::LF[7:0], 1'b0);
            if ($urandom_range(1)) send_item(utt_pkg::LF[7:0], 1'b0);
        end else if (pick < 55) begin
            cp = 21'($urandom_range(21'h7FF, 21'h80));
            send_item({3'b110, cp[10:6]}, 1'b0);
            send_item({2'b10, cp[5:0]}, 1'b0);
        end else if (pick < 70) begin
            cp = ($urandom_range(9) == 0) ? {5'h0, utt_pkg::BOM}
                                          : 21'($urandom_range(21'hFFFF, 21'h800));
            send_item({4'b1110, cp[15:12]}, 1'b0);
            send_item({2'b10, cp[11:6]}, 1'b0);
            send_item({2'b10, cp[5:0]}, 1'b0);
        end else if (pick < 82) begin
            cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            send_item({5'b11110, cp[20:18]}, 1'b0);
            send_item({2'b10, cp[17:12]}, 1'b0);
            send_item({2'b10, cp[11:6]}, 1'b0);
            send_item({2'b10, cp[5:0]}, 1'b0);
        end else if (pick < 90) begin
            n = $urandom_range(5, 3);
            if (n == 3) lead = 8'($urandom_range(8'hF7, 8'hF4));
            else if (n == 4) lead = 8'($urandom_range(8'hFB, 8'hF8));
            else lead = 8'($urandom_range(8'hFF, 8'hFC));
            send_item(lead, 1'b0);
            repeat (n) send_item(cont_byte(), 1'b0);
        end else if (pick < 94) begin
            send_item(8'($urandom_range(255)), 1'b0);
        end else if (pick < 97) begin
            send_item(8'($urandom_range(8'hEF, 8'hE0)), 1'b0);
            send_item(cont_byte(), 1'b0);
            send_item(8'($urandom_range(255)), 1'b1);
        end else begin
            send_item(8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic utf16_unit(input logic [15:0] unit);
        if (cur_enc == utt_pkg::ENC_UTF16BE) begin
            send_item(unit[15:8], 1'b0);
            send_item(unit[7:0], 1'b0);
        end else begin
            send_item(unit[7:0], 1'b0);
            send_item(unit[15:8], 1'b0);
        end
    endtask

    task automatic utf16_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            utf16_unit(16'($urandom_range(16'hFFFF)));
        end else if (pick < 55) begin
            utf16_unit(16'($urandom_range(16'h7E, 16'h20)));
        end else if (pick < 65) begin
            utf16_unit($urandom_range(1) ? utt_pkg::CR : utt_pkg::LF);
        end else if (pick < 80) begin
            utf16_unit(16'($urandom_range(16'hDBFF, 16'hD800)));
            utf16_unit(16'($urandom_range(16'hDFFF, 16'hDC00)));
        end else if (pick < 85) begin
            utf16_unit(utt_pkg::BOM);
        end else if (pick < 95) begin
            send_item(8'($urandom_range(255)), 1'b1);
        end else begin
            send_item(8'($urandom_range(255)), 1'b0);
            send_item(8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic run_phase(input logic [1:0] enc, input int tx, input int rx,
                             input int count, input bit with_hold, input bit with_pause);
        int stop_at;
        int mid;
        settle();
        write_encoding(enc);
        tx_idle_pct = tx;
        rx_stall_pct <= rx;
        stop_at = sent + count;
        mid     = sent + count / 2;
        while (sent < stop_at) begin
            if (sent >= mid && with_hold) begin
                with_hold = 1'b0;
                hold_req <= ~hold_req;
            end
            if (sent >= mid && with_pause) begin
                with_pause = 1'b0;
                settle();
            end
            if (enc == utt_pkg::ENC_UTF16LE || enc == utt_pkg::ENC_UTF16BE) utf16_char();
            else utf8_char();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(8'h00, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(utt_pkg::CR[7:0], 1'b0);
        send_item(utt_pkg::LF[7:0], 1'b0);
        send_item(8'hC3, 1'b0); send_item(8'hA9, 1'b0);
        send_item(8'hC3, 1'b0); send_item(8'h41, 1'b0);
        send_item(8'hEF, 1'b0); send_item(8'hBB, 1'b0); send_item(8'hBF, 1'b0);
        send_item(8'hF0, 1'b0); send_item(8'h9F, 1'b0);
        send_item(8'h98, 1'b0); send_item(8'h80, 1'b0);
        send_item(8'h85, 1'b0);
        send_item(8'hFF, 1'b0);
        repeat (5) send_item(8'hFF, 1'b0);
        send_item(8'h5A, 1'b1);
        send_item(8'hF4, 1'b0);
        send_item(8'hA5, 1'b1);

        run_phase(utt_pkg::ENC_UTF8,    0,  0,  250, 1'b1, 1'b0);
        run_phase(utt_pkg::ENC_UTF16LE, 50, 0,  200, 1'b0, 1'b1);
        run_phase(utt_pkg::ENC_UTF16BE, 0,  50, 200, 1'b0, 1'b0);
        run_phase(ENC_SPARE,            6,  6,  150, 1'b0, 1'b0);
        run_phase(utt_pkg::ENC_UTF8,    0,  50, 200, 1'b0, 1'b1);
        run_phase(utt_pkg::ENC_UTF16BE, 6,  6,  150, 1'b0, 1'b0);
        run_phase(utt_pkg::ENC_UTF16LE, 0,  0,  150, 1'b1, 1'b0);
        run_phase(utt_pkg::ENC_UTF8,    50, 6,  100, 1'b0, 1'b0);

        settle();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d bytes across UTF-8, UTF-16 LE/BE and the spare encoding code,",
                 sent);
        $display("with idle, stall and backpressure phases; %0d results compared, %0d words.",
                 checked, words);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
